@@ hw/rtl/pve_pkg.sv @@
// Shared types and constants for the pointer velocity estimator.
`timescale 1ns / 1ps
`default_nettype none
package pve_pkg;

  localparam int SAMPLE_DEPTH_DEF = 8;
  localparam int POS_W            = 32;
  localparam int TS_W             = 48;
  localparam int DT_W             = 32;
  localparam int TU_W             = 20;
  localparam int MV_W             = 31;
  localparam int CFG_ADDR_W       = 1;
  localparam int CFG_DATA_W       = 31;

  localparam logic [CFG_ADDR_W-1:0] CFG_TIME_UNITS   = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_VELOCITY = 1'd1;

  localparam logic [TU_W-1:0] TIME_UNITS_RST   = 20'd1000;
  localparam logic [MV_W-1:0] MAX_VELOCITY_RST = 31'h7FFF_FFFF;

  typedef struct packed {
    logic                    command;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [TS_W-1:0]         timestamp;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] velocity_x;
    logic signed [POS_W-1:0] velocity_y;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_FIRST,
    OP_UPDATE
  } op_kind_t;

  typedef struct packed {
    op_kind_t                kind;
    logic signed [POS_W-1:0] dx;
    logic signed [POS_W-1:0] dy;
    logic [DT_W-1:0]         dt;
  } op_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_READ,
    BK_ACC,
    BK_MEAN,
    BK_MEAN_WAIT,
    BK_MUL,
    BK_DIV,
    BK_DIV_WAIT,
    BK_DONE
  } back_state_t;

  // Saturate a 33-bit difference to the signed 32-bit range.
  function automatic logic signed [POS_W-1:0] sat_diff(input logic [POS_W:0] d);
    logic signed [POS_W-1:0] r;
    if (d[POS_W] != d[POS_W-1]) begin
      r = d[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      r = d[POS_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/pointer_velocity_estimator_core.sv @@
// Top level of the pointer velocity estimator.
// Usage:
//   Input queue port: drive in_data and raise in_push; a transaction completes
//   at an edge with in_push high and in_full low. A command of 1 clears the
//   window and the stored position; a sample with no stored time latches
//   position and time and empties the window. Neither gives a result.
//   Result queue port: while out_empty is low, out_data holds the oldest
//   velocity; raise out_pop to take it.
//   Config: cfg_we with cfg_addr 0 writes time_units, 1 writes max_velocity.
//   Write only while the block is idle.
// Operation:
//   A front stage forms deltas and queues up to two operations. The back end
//   handles one update at a time: ring read and sum update, a serial mean
//   time division, a multiply, then the x and y serial divisions in parallel.
//   Each division works through an NW = 52 + clog2(SAMPLE_DEPTH+1) bit
//   numerator (56 at depth 8), and an update occupies the back end until
//   both divisions end and its result is loaded; clear and first samples
//   are taken while the back end is idle. The serial dividers set the rate.
//   When out_pop stays low the finished result waits in its register, the
//   back end holds, the queue fills and in_full rises.
//   Reset (synchronous, rst_n low) empties everything and restores
//   time_units = 1000 and max_velocity = 2^31-1.
`timescale 1ns / 1ps
`default_nettype none
module pointer_velocity_estimator_core #(
  parameter int SAMPLE_DEPTH = pve_pkg::SAMPLE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  input  wire pve_pkg::in_item_t               in_data,
  output logic                                 in_full,
  output logic                                 out_empty,
  output pve_pkg::out_item_t                   out_data,
  input  wire logic                            out_pop,
  input  wire logic                            cfg_we,
  input  wire logic [pve_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [pve_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic [pve_pkg::TU_W-1:0] time_units_r;
  logic [pve_pkg::MV_W-1:0] max_velocity_r;
  logic                     op_valid, op_pop, res_valid;
  pve_pkg::op_t             op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_units_r   <= pve_pkg::TIME_UNITS_RST;
      max_velocity_r <= pve_pkg::MAX_VELOCITY_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        pve_pkg::CFG_TIME_UNITS:   time_units_r   <= cfg_wdata[pve_pkg::TU_W-1:0];
        pve_pkg::CFG_MAX_VELOCITY: max_velocity_r <= cfg_wdata[pve_pkg::MV_W-1:0];
        default: ;
      endcase
    end
  end

  pve_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .data     (in_data),
    .full     (in_full),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop)
  );

  pve_back #(.SAMPLE_DEPTH(SAMPLE_DEPTH)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .op_valid     (op_valid),
    .op           (op),
    .op_pop       (op_pop),
    .time_units   (time_units_r),
    .max_velocity (max_velocity_r),
    .res_valid    (res_valid),
    .res          (out_data),
    .res_pop      (out_pop)
  );

  assign out_empty = !res_valid;

endmodule
`default_nettype wire

@@ hw/rtl/pve_ram.sv @@
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module pve_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ hw/rtl/pve_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module pve_div #(
  parameter int NW = 56,
  parameter int DW = 36
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               busy,
  output logic [NW-1:0]      quo
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_r, num_nxt;
  logic [DW-1:0] den_r;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem_r, num_r[NW-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    rem_nxt = ge ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
    num_nxt = {num_r[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign quo  = num_r;

endmodule
`default_nettype wire

@@ hw/rtl/pve_front.sv @@
// Front end: accepts samples, forms deltas and queues window operations.
`timescale 1ns / 1ps
`default_nettype none
module pve_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire pve_pkg::in_item_t data,
  output logic                   full,
  output logic                   op_valid,
  output pve_pkg::op_t           op,
  input  wire logic              op_pop
);

  logic signed [pve_pkg::POS_W-1:0] last_x_r, last_y_r;
  logic [pve_pkg::TS_W-1:0]         last_t_r;
  pve_pkg::op_t                     q_r [2];
  logic                             wp_r, rp_r;
  logic [1:0]                       cnt_r;
  logic                             accept;
  pve_pkg::op_t                     new_op;
  logic [pve_pkg::TS_W-1:0]         dt_full;

  assign full   = (cnt_r == 2'd2);
  assign accept = push && !full;
  assign dt_full = data.timestamp - last_t_r;

  always_comb begin
    new_op.dx = pve_pkg::sat_diff({data.pos_x[31], data.pos_x} - {last_x_r[31], last_x_r});
    new_op.dy = pve_pkg::sat_diff({data.pos_y[31], data.pos_y} - {last_y_r[31], last_y_r});
    new_op.dt = (|dt_full[pve_pkg::TS_W-1:pve_pkg::DT_W]) ? '1 : dt_full[pve_pkg::DT_W-1:0];
    if (data.command) begin
      new_op.kind = pve_pkg::OP_CLEAR;
    end else if (last_t_r == '0) begin
      new_op.kind = pve_pkg::OP_FIRST;
    end else begin
      new_op.kind = pve_pkg::OP_UPDATE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r <= '0;
      last_y_r <= '0;
      last_t_r <= '0;
      wp_r     <= 1'b0;
      rp_r     <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (accept) begin
        if (data.command) begin
          last_x_r <= '0;
          last_y_r <= '0;
          last_t_r <= '0;
        end else begin
          last_x_r <= data.pos_x;
          last_y_r <= data.pos_y;
          last_t_r <= data.timestamp;
        end
        wp_r <= ~wp_r;
      end
      if (op_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, accept} - {1'b0, op_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wp_r] <= new_op;
    end
  end

  assign op_valid = (cnt_r != 2'd0);
  assign op       = q_r[rp_r];

endmodule
`default_nettype wire

@@ hw/rtl/pve_back.sv @@
// Back end: window ring, running sums, velocity division and result register.
`timescale 1ns / 1ps
`default_nettype none
module pve_back #(
  parameter int SAMPLE_DEPTH = pve_pkg::SAMPLE_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      op_valid,
  input  wire pve_pkg::op_t              op,
  output logic                           op_pop,
  input  wire logic [pve_pkg::TU_W-1:0]  time_units,
  input  wire logic [pve_pkg::MV_W-1:0]  max_velocity,
  output logic                           res_valid,
  output pve_pkg::out_item_t             res,
  input  wire logic                      res_pop
);

  localparam int AW   = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int CNTW = $clog2(SAMPLE_DEPTH + 1);
  localparam int SUMW = pve_pkg::POS_W + CNTW;
  localparam int NW   = SUMW + pve_pkg::TU_W;
  localparam int RW   = 2 * pve_pkg::POS_W + pve_pkg::DT_W;

  pve_pkg::back_state_t state_r, state_nxt;

  pve_pkg::op_t          cur_r;
  logic [AW-1:0]         slot_r;
  logic [CNTW-1:0]       filled_r;
  logic signed [SUMW-1:0] sum_x_r, sum_y_r;
  logic [SUMW-1:0]       sum_t_r;
  logic [SUMW-1:0]       den_r;
  logic [NW-1:0]         num_x_r, num_y_r;
  logic                  neg_x_r, neg_y_r;
  logic                  res_valid_r;
  pve_pkg::out_item_t    res_r;

  logic                  ram_we;
  logic [RW-1:0]         ram_rdata;
  logic                  win_full;
  logic signed [pve_pkg::POS_W-1:0] old_dx, old_dy;
  logic [pve_pkg::DT_W-1:0]         old_dt;

  logic                  div_x_start, div_y_start;
  logic [NW-1:0]         div_x_num;
  logic [SUMW-1:0]       div_x_den;
  logic                  div_x_busy, div_y_busy;
  logic [NW-1:0]         quo_x, quo_y;
  logic                  res_load;

  logic [SUMW-1:0]       mag_x, mag_y;
  logic [CNTW+SUMW-1:0]  den_full;
  logic [NW-1:0]         clamp_x, clamp_y;
  logic [pve_pkg::POS_W-1:0] vx, vy;

  assign win_full = (filled_r == CNTW'(SAMPLE_DEPTH));
  assign {old_dx, old_dy, old_dt} = ram_rdata;

  pve_ram #(.WIDTH(RW), .DEPTH(SAMPLE_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata ({cur_r.dx, cur_r.dy, cur_r.dt}),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  // The x divider first finds the mean time delta, then the x quotient.
  always_comb begin
    if (state_r == pve_pkg::BK_MEAN) begin
      div_x_num = NW'(sum_t_r);
      div_x_den = SUMW'(filled_r);
    end else begin
      div_x_num = num_x_r;
      div_x_den = den_r;
    end
  end

  pve_div #(.NW(NW), .DW(SUMW)) u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_x_start),
    .num   (div_x_num),
    .den   (div_x_den),
    .busy  (div_x_busy),
    .quo   (quo_x)
  );

  pve_div #(.NW(NW), .DW(SUMW)) u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_y_start),
    .num   (num_y_r),
    .den   (den_r),
    .busy  (div_y_busy),
    .quo   (quo_y)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pve_pkg::BK_IDLE: begin
        if (op_valid && op.kind == pve_pkg::OP_UPDATE) begin
          state_nxt = pve_pkg::BK_READ;
        end
      end
      pve_pkg::BK_READ:      state_nxt = pve_pkg::BK_ACC;
      pve_pkg::BK_ACC:       state_nxt = pve_pkg::BK_MEAN;
      pve_pkg::BK_MEAN:      state_nxt = pve_pkg::BK_MEAN_WAIT;
      pve_pkg::BK_MEAN_WAIT: begin
        if (!div_x_busy) begin
          state_nxt = pve_pkg::BK_MUL;
        end
      end
      pve_pkg::BK_MUL:       state_nxt = pve_pkg::BK_DIV;
      pve_pkg::BK_DIV:       state_nxt = pve_pkg::BK_DIV_WAIT;
      pve_pkg::BK_DIV_WAIT: begin
        if (!div_x_busy && !div_y_busy) begin
          state_nxt = pve_pkg::BK_DONE;
        end
      end
      pve_pkg::BK_DONE: begin
        if (!res_valid_r) begin
          state_nxt = pve_pkg::BK_IDLE;
        end
      end
      default:               state_nxt = pve_pkg::BK_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    op_pop      = 1'b0;
    ram_we      = 1'b0;
    div_x_start = 1'b0;
    div_y_start = 1'b0;
    res_load    = 1'b0;
    case (state_r)
      pve_pkg::BK_IDLE: op_pop = op_valid;
      pve_pkg::BK_ACC:  ram_we = 1'b1;
      pve_pkg::BK_MEAN: div_x_start = 1'b1;
      pve_pkg::BK_DIV: begin
        div_x_start = 1'b1;
        div_y_start = 1'b1;
      end
      pve_pkg::BK_DONE: res_load = !res_valid_r;
      default: ;
    endcase
  end

  assign mag_x    = sum_x_r[SUMW-1] ? SUMW'(-sum_x_r) : sum_x_r;
  assign mag_y    = sum_y_r[SUMW-1] ? SUMW'(-sum_y_r) : sum_y_r;
  assign den_full = filled_r * quo_x[SUMW-1:0];

  assign clamp_x = (quo_x > NW'(max_velocity)) ? NW'(max_velocity) : quo_x;
  assign clamp_y = (quo_y > NW'(max_velocity)) ? NW'(max_velocity) : quo_y;

  always_comb begin
    if (den_r == '0) begin
      vx = '0;
      vy = '0;
    end else begin
      vx = neg_x_r ? pve_pkg::POS_W'(-clamp_x) : clamp_x[pve_pkg::POS_W-1:0];
      vy = neg_y_r ? pve_pkg::POS_W'(-clamp_y) : clamp_y[pve_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pve_pkg::BK_IDLE;
      slot_r      <= '0;
      filled_r    <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_t_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == pve_pkg::BK_IDLE && op_valid && op.kind != pve_pkg::OP_UPDATE) begin
        slot_r   <= '0;
        filled_r <= '0;
        sum_x_r  <= '0;
        sum_y_r  <= '0;
        sum_t_r  <= '0;
      end
      if (state_r == pve_pkg::BK_ACC) begin
        // When the window is full the overwritten entry leaves the sums.
        sum_x_r <= sum_x_r + SUMW'(cur_r.dx) - (win_full ? SUMW'(old_dx) : '0);
        sum_y_r <= sum_y_r + SUMW'(cur_r.dy) - (win_full ? SUMW'(old_dy) : '0);
        sum_t_r <= sum_t_r + SUMW'(cur_r.dt) - (win_full ? SUMW'(old_dt) : '0);
        slot_r  <= (slot_r == AW'(SAMPLE_DEPTH - 1)) ? '0 : slot_r + 1'b1;
        if (!win_full) begin
          filled_r <= filled_r + 1'b1;
        end
      end
      if (res_load) begin
        res_valid_r <= 1'b1;
      end else if (res_pop) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == pve_pkg::BK_IDLE && op_valid) begin
      cur_r <= op;
    end
    if (state_r == pve_pkg::BK_MUL) begin
      den_r   <= den_full[SUMW-1:0];
      num_x_r <= mag_x * time_units;
      num_y_r <= mag_y * time_units;
      neg_x_r <= sum_x_r[SUMW-1];
      neg_y_r <= sum_y_r[SUMW-1];
    end
    if (res_load) begin
      res_r.velocity_x <= vx;
      res_r.velocity_y <= vy;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= CNTW'(SAMPLE_DEPTH))
    else $error("window count above depth");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> !res_valid_r)
    else $error("result register overwritten");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pve_pkg::BK_IDLE && op_valid && op.kind == pve_pkg::OP_CLEAR)
      |=> (filled_r == '0 && slot_r == '0))
    else $error("clear did not empty window");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (div_x_start || div_y_start) |-> (!div_x_busy && !div_y_busy))
    else $error("divider restarted while busy");

endmodule
`default_nettype wire
